// ----- sv/sum_checksum_packet_deframer_core_macros.svh -----
// Assertion macros shared by the deframer's checker.
// Depends on nothing; included by the checker file by bare name.
`ifndef SUM_CHECKSUM_PACKET_DEFRAMER_CORE_MACROS_SVH
`define SUM_CHECKSUM_PACKET_DEFRAMER_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define SCPD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("deframer assertion failed");

// Clocked assertion that also holds during reset.
`define SCPD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("deframer reset assertion failed");

`endif

// ----- sv/scpd_pkg.sv -----
// Types and constants shared by the packet deframer modules.
// Depends on nothing.
`default_nettype none

package scpd_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int LEN_W       = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_START  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_START = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH   = 2'd2;

   localparam logic [7:0]       FIRST_START_RESET  = 8'd170;
   localparam logic [7:0]       SECOND_START_RESET = 8'd175;
   localparam logic [LEN_W-1:0] MAX_LENGTH_RESET   = 6'd30;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic             status;
      logic [7:0]       msg_id;
      logic [LEN_W-1:0] payload_length;
      logic             has_payload;
      logic [7:0]       payload_byte;
      logic             last;
   } rsp_type;

   // One finished frame handed from the parser to the emitter.
   typedef struct packed {
      logic             is_err;
      logic [7:0]       msg_id;
      logic [LEN_W-1:0] length;
   } cmd_type;

   // What the parser must know about the far side before it takes a byte.
   typedef struct packed {
      logic q_empty;
      logic q_full;
      logic back_idle;
   } hold_type;

   typedef enum logic [2:0] {
      PH_START1 = 3'd0,
      PH_START2 = 3'd1,
      PH_ID     = 3'd2,
      PH_LEN    = 3'd3,
      PH_DATA   = 3'd4,
      PH_SUM    = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      BK_IDLE   = 2'd0,
      BK_SINGLE = 2'd1,
      BK_READ   = 2'd2,
      BK_DATA   = 2'd3
   } back_state_type;

endpackage

`default_nettype wire

// ----- sv/sum_checksum_packet_deframer_core.sv -----
// Serial packet deframer with an 8-bit additive checksum. Each transfer on
// the req_ channel is one received byte (mode 0) or a receive timeout
// (mode 1). While a frame header is parsed the block takes one transfer per
// cycle. A payload byte waits until the emitter is idle and the command
// queue is empty, so that no earlier frame still needs the shared payload
// buffer, and a checksum byte waits only when the two-entry command queue is
// full. Results leave through a registered rsp_ output: one result for an
// empty packet or a checksum mismatch, otherwise one result per payload byte
// with last on the final one. For each payload byte the emitter first reads
// the byte from memory in its read state and then loads the output register
// in its data state; a single result is loaded from its own state once its
// command is taken. Once the last result is loaded the emitter returns to
// idle and can take a queued command in the following cycle. The payload
// buffer needs no clearing after reset.
// Depends on scpd_pkg and the parser, queue and emitter modules.
`default_nettype none

module sum_checksum_packet_deframer_core #(
   parameter int MAX_PAYLOAD = scpd_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_we,
   input  wire  [scpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire  [scpd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  scpd_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output scpd_pkg::rsp_type                rsp_data
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   // Buffer write port from the parser to the emitter's memory.
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;

   // Command handoff through the queue.
   logic              push;
   logic              pop;
   scpd_pkg::cmd_type push_cmd;
   scpd_pkg::cmd_type head;
   scpd_pkg::hold_type hold;
   logic              q_empty;
   logic              q_full;
   logic              back_idle;

   assign hold.q_empty   = q_empty;
   assign hold.q_full    = q_full;
   assign hold.back_idle = back_idle;

   // The parser checks the start bytes, accumulates the checksum and stores
   // payload bytes; at the checksum byte it pushes a pass or fail command.
   scpd_parser #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .hold      (hold),
      .push      (push),
      .push_cmd  (push_cmd),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   scpd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   // The emitter turns each command into results, reading payload bytes
   // back from the buffer in order of reception.
   scpd_emitter #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_emitter (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .head      (head),
      .q_empty   (q_empty),
      .pop       (pop),
      .back_idle (back_idle),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- sv/scpd_parser.sv -----
// Front end: configuration registers and the frame parser state machine.
// Depends on scpd_pkg; writes the payload buffer and pushes frame commands.
`default_nettype none

module scpd_parser #(
   parameter int MAX_PAYLOAD = scpd_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_we,
   input  wire  [scpd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [scpd_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  scpd_pkg::req_type                    req_data,
   input  scpd_pkg::hold_type                   hold,
   output logic                                 push,
   output scpd_pkg::cmd_type                    push_cmd,
   output logic                                 wr_en,
   output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] wr_addr,
   output logic [7:0]                           wr_data
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int LW = scpd_pkg::LEN_W;
   localparam logic [7:0] MAX_P8 = 8'(MAX_PAYLOAD);

   logic [7:0]    first_ff;
   logic [7:0]    second_ff;
   logic [LW-1:0] maxlen_ff;

   scpd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]    sum_ff, sum_in;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic [7:0]    id_ff, id_in;
   logic [LW-1:0] len_ff, len_in;

   logic       accept;
   logic [7:0] c;
   logic [7:0] limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= scpd_pkg::FIRST_START_RESET;
         second_ff <= scpd_pkg::SECOND_START_RESET;
         maxlen_ff <= scpd_pkg::MAX_LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            scpd_pkg::CSR_FIRST_START:  first_ff  <= csr_wdata;
            scpd_pkg::CSR_SECOND_START: second_ff <= csr_wdata;
            scpd_pkg::CSR_MAX_LENGTH:   maxlen_ff <= csr_wdata[LW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= scpd_pkg::PH_START1;
         sum_ff   <= '0;
         cnt_ff   <= '0;
         id_ff    <= '0;
         len_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
      end
   end

   assign c      = req_data.rx_byte;
   assign accept = req_valid && req_ready;
   assign limit  = ({2'b00, maxlen_ff} > MAX_P8) ? MAX_P8 : {2'b00, maxlen_ff};

   // Payload bytes may only overwrite the buffer once the emitter has read
   // everything queued; a checksum byte needs a free queue slot.
   always_comb begin
      case (phase_ff)
         scpd_pkg::PH_DATA: req_ready = hold.back_idle && hold.q_empty;
         scpd_pkg::PH_SUM:  req_ready = !hold.q_full;
         default:           req_ready = 1'b1;
      endcase
   end

   always_comb begin
      phase_in        = phase_ff;
      sum_in          = sum_ff;
      cnt_in          = cnt_ff;
      id_in           = id_ff;
      len_in          = len_ff;
      push            = 1'b0;
      push_cmd.is_err = (sum_ff != c);
      push_cmd.msg_id = id_ff;
      push_cmd.length = len_ff;
      wr_en           = 1'b0;
      wr_addr         = AW'(cnt_ff);
      wr_data         = c;
      if (accept) begin
         if (req_data.mode) begin
            phase_in = scpd_pkg::PH_START1;
         end else begin
            case (phase_ff)
               scpd_pkg::PH_START1: begin
                  phase_in = (c == first_ff) ? scpd_pkg::PH_START2 : scpd_pkg::PH_START1;
                  sum_in   = c;
               end
               scpd_pkg::PH_START2: begin
                  phase_in = (c == second_ff) ? scpd_pkg::PH_ID : scpd_pkg::PH_START1;
                  sum_in   = sum_ff + c;
               end
               scpd_pkg::PH_ID: begin
                  id_in    = c;
                  sum_in   = sum_ff + c;
                  phase_in = scpd_pkg::PH_LEN;
               end
               scpd_pkg::PH_LEN: begin
                  if (c <= limit) begin
                     len_in   = c[LW-1:0];
                     cnt_in   = '0;
                     sum_in   = sum_ff + c;
                     phase_in = (c != 8'd0) ? scpd_pkg::PH_DATA : scpd_pkg::PH_SUM;
                  end else begin
                     phase_in = scpd_pkg::PH_START1;
                  end
               end
               scpd_pkg::PH_DATA: begin
                  wr_en  = ({2'b00, cnt_ff} < MAX_P8);
                  cnt_in = cnt_ff + 1'b1;
                  sum_in = sum_ff + c;
                  if (cnt_in >= len_ff) begin
                     phase_in = scpd_pkg::PH_SUM;
                  end
               end
               scpd_pkg::PH_SUM: begin
                  push     = 1'b1;
                  phase_in = scpd_pkg::PH_START1;
               end
               default: begin
                  phase_in = (c == first_ff) ? scpd_pkg::PH_START2 : scpd_pkg::PH_START1;
                  sum_in   = c;
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ----- sv/scpd_queue.sv -----
// Short command queue between the parser and the emitter.
// Depends on scpd_pkg for the command type and the queue depth.
`default_nettype none

module scpd_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  scpd_pkg::cmd_type push_cmd,
   input  wire               pop,
   output scpd_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);

   localparam int DEPTH = scpd_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   scpd_pkg::cmd_type entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CW'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- sv/scpd_emitter.sv -----
// Back end: payload buffer memory and the result sequencer with its
// output register. Depends on scpd_pkg.
`default_nettype none

module scpd_emitter #(
   parameter int MAX_PAYLOAD = scpd_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                wr_en,
   input  wire  [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1)-1:0] wr_addr,
   input  wire  [7:0]         wr_data,
   input  scpd_pkg::cmd_type  head,
   input  wire                q_empty,
   output logic               pop,
   output logic               back_idle,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output scpd_pkg::rsp_type  rsp_data
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int LW = scpd_pkg::LEN_W;

   logic [7:0] mem [MAX_PAYLOAD];
   logic [7:0] rdata_ff;
   logic       rd_en;

   scpd_pkg::back_state_type state_ff, state_in;
   scpd_pkg::cmd_type cmd_ff, cmd_in;
   logic [LW-1:0] idx_ff, idx_in;

   logic              rsp_valid_ff;
   scpd_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              load;
   logic              out_free;
   logic              is_last;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[AW'(idx_ff)];
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_last   = ((idx_ff + 1'b1) == cmd_ff.length);
   assign back_idle = (state_ff == scpd_pkg::BK_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      pop         = 1'b0;
      rd_en       = 1'b0;
      load        = 1'b0;
      rsp_data_in.status         = cmd_ff.is_err;
      rsp_data_in.msg_id         = cmd_ff.msg_id;
      rsp_data_in.payload_length = cmd_ff.length;
      rsp_data_in.has_payload    = 1'b0;
      rsp_data_in.payload_byte   = 8'd0;
      rsp_data_in.last           = 1'b1;
      case (state_ff)
         scpd_pkg::BK_IDLE: begin
            if (!q_empty) begin
               pop    = 1'b1;
               cmd_in = head;
               idx_in = '0;
               state_in = (head.is_err || head.length == '0) ?
                          scpd_pkg::BK_SINGLE : scpd_pkg::BK_READ;
            end
         end
         scpd_pkg::BK_SINGLE: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = scpd_pkg::BK_IDLE;
            end
         end
         scpd_pkg::BK_READ: begin
            rd_en    = 1'b1;
            state_in = scpd_pkg::BK_DATA;
         end
         scpd_pkg::BK_DATA: begin
            rsp_data_in.status       = 1'b0;
            rsp_data_in.has_payload  = 1'b1;
            rsp_data_in.payload_byte = rdata_ff;
            rsp_data_in.last         = is_last;
            if (out_free) begin
               load = 1'b1;
               if (is_last) begin
                  state_in = scpd_pkg::BK_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = scpd_pkg::BK_READ;
               end
            end
         end
         default: state_in = scpd_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scpd_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- sv/scpd_checker.sv -----
// Port-level checks on the deframer's result channel, bound to the top.
// Depends on scpd_pkg and the assertion macro header.
`default_nettype none
`include "sum_checksum_packet_deframer_core_macros.svh"

module scpd_checker (
   input wire               clock,
   input wire               reset,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input scpd_pkg::rsp_type rsp_data
);

   `SCPD_ASSERT_ALWAYS(a_reset_clears_valid, clock, reset |=> !rsp_valid)
   `SCPD_ASSERT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
   `SCPD_ASSERT(a_single_is_last, clock, reset, rsp_valid && !rsp_data.has_payload |-> rsp_data.last)
   `SCPD_ASSERT(a_error_no_data, clock, reset, rsp_valid && rsp_data.status |-> !rsp_data.has_payload && rsp_data.payload_byte == 8'd0)
   `SCPD_ASSERT(a_data_has_length, clock, reset, rsp_valid && rsp_data.has_payload |-> rsp_data.payload_length != 6'd0)

endmodule

bind sum_checksum_packet_deframer_core scpd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
